>>> rtl/core/ufrc_pkg.sv
package ufrc_pkg;

  localparam int FRAME_DEPTH = 64;
  localparam int MAX_RESULTS = 60;
  localparam int ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);
  // wide enough for length + 5 and for the byte count
  localparam int POS_W       = ((CNT_W > 9) ? CNT_W : 9) + 1;
  localparam int CFG_IDX_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT     = CFG_IDX_W'(1);

  localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd300;
  localparam logic [15:0] CRC_INIT_RESET     = 16'h0000;
  localparam logic [15:0] CRC_POLY_REFL      = 16'hA001;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_K = 8'h4B;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_W = 8'h57;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [2:0] {
    KIND_ACK   = 3'd0,
    KIND_NACK  = 3'd1,
    KIND_GOOD  = 3'd2,
    KIND_BAD   = 3'd3,
    KIND_OTHER = 3'd4
  } frame_kind_t;

  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_ACK  = 2'd1,
    REPLY_NACK = 2'd2
  } reply_t;

  typedef struct packed {
    logic        load;
    logic [15:0] load_value;
    logic        start;
    logic [7:0]  data;
  } crc_cmd_t;

endpackage

>>> rtl/core/ufrc_ram.sv
module ufrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/ufrc_crc_serial.sv
module ufrc_crc_serial (
  input  logic               clk,
  input  logic               rst,
  input  ufrc_pkg::crc_cmd_t cmd,
  output logic               busy,
  output logic [15:0]        crc
);

  import ufrc_pkg::*;

  logic [2:0] bit_cnt;

  // one bit of the reflected CRC per cycle; byte is folded in on start
  always_ff @(posedge clk) begin
    if (rst) begin
      crc     <= CRC_INIT_RESET;
      busy    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      priority if (cmd.load) begin
        crc  <= cmd.load_value;
        busy <= 1'b0;
      end else if (cmd.start) begin
        crc     <= crc ^ {8'h00, cmd.data};
        busy    <= 1'b1;
        bit_cnt <= '0;
      end else begin
        if (busy) begin
          crc     <= (crc >> 1) ^ (crc[0] ? CRC_POLY_REFL : 16'h0000);
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

endmodule

>>> rtl/core/uart_frame_receive_classifier_unit.sv
// Channel | Dir | Handshake           | Content
// s       | in  | s_tvalid / s_tready | tdata rx_byte, tuser cmd
// m       | out | m_tvalid / m_tready | tdata reply..payload_byte, tuser kind/pv, tlast
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (16 bit)
//
// A byte item is accepted, stepped bit by bit through the bit-serial CRC unit, and
// its result taken before the next item is accepted. A tick item is taken in idle;
// the tick that ends a frame starts the classifier, which zero-fills each missing
// byte before the CRC field through the CRC unit and does one store read per payload byte.
// Synchronous reset; the frame store needs no clearing. An output register
// holds each result, so the input side is free while the final result waits.
module uart_frame_receive_classifier_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
  input  logic                           s_tuser,   // [0] cmd
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [39:0]                    m_tdata,   // [1:0] reply, [9:2] msg_id,
                                                    // [17:10] msg_type,
                                                    // [25:18] msg_length,
                                                    // [33:26] payload_byte, rest 0
  output logic [3:0]                     m_tuser,   // [2:0] frame_kind, [3] payload_valid
  output logic                           m_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ufrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);

  import ufrc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CRC, S_CLASS, S_EXT_GO, S_EXT_WAIT,
    S_RDHI, S_RDLO, S_CMP, S_PRD, S_PEMIT
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [15:0]        idle_cnt;
  logic               overflowed;
  logic [15:0]        crc_end;
  logic               cap_pend;
  logic [7:0]         b0, b1, b2, b3;
  logic [15:0]        idle_timeout;
  logic [15:0]        crc_init;
  logic [POS_W-1:0]   ext_left;
  logic [15:0]        crc_chk;
  logic [7:0]         rx_hi;
  logic [7:0]         pay_idx;

  logic               out_valid;
  frame_kind_t        out_kind;
  reply_t             out_reply;
  logic [7:0]         out_id, out_type, out_len, out_pb;
  logic               out_pv, out_last;

  crc_cmd_t           crc_cmd;
  logic               crc_busy;
  logic [15:0]        crc_val;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [7:0]         ram_rdata;

  logic               in_acc, byte_acc, tick_acc, out_free;
  logic [POS_W-1:0]   cnt_w, len_w, end_pos, new_cnt, len_eff, pay_pos;
  logic [15:0]        idle_next;
  logic               is_ack, is_nack, is_msg, len_bad, crc_good, pos_ok, cap_now;

  logic               emit, emit_last;
  frame_kind_t        r_kind;
  reply_t             r_reply;
  logic [7:0]         r_id, r_type, r_len, r_pb;
  logic               r_pv, r_last;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid & s_tready;
  assign byte_acc  = in_acc && (s_tuser == CMD_BYTE) && (count < CNT_W'(FRAME_DEPTH));
  assign tick_acc  = in_acc && (s_tuser == CMD_TICK);
  assign out_free  = !out_valid || m_tready;

  assign cnt_w   = POS_W'(count);
  assign len_w   = POS_W'(b2);
  assign end_pos = len_w + POS_W'(3);
  assign new_cnt = cnt_w + POS_W'(1);
  assign len_eff = POS_W'((count == CNT_W'(2)) ? s_tdata : b2);
  assign cap_now = (new_cnt >= POS_W'(3)) && (new_cnt == len_eff + POS_W'(3));
  assign pay_pos = POS_W'(pay_idx) + POS_W'(3);
  assign pos_ok  = pay_pos < cnt_w;

  assign idle_next = (idle_cnt == 16'hFFFF) ? idle_cnt : idle_cnt + 16'd1;

  assign is_ack  = (count == CNT_W'(3)) && (b0 == CH_A) && (b1 == CH_C) && (b2 == CH_K);
  assign is_nack = (count == CNT_W'(4)) && (b0 == CH_N) && (b1 == CH_A) &&
                   (b2 == CH_C) && (b3 == CH_K);
  assign is_msg  = (count > CNT_W'(5)) && (b1 == CH_W);
  assign len_bad = (len_w + POS_W'(5) > POS_W'(FRAME_DEPTH)) ||
                   (b2 > 8'(MAX_RESULTS - 1));
  // low CRC byte is on the read port while in S_CMP
  assign crc_good = {rx_hi, ((end_pos + POS_W'(1)) < cnt_w) ? ram_rdata : 8'h00} == crc_chk;

  always_comb begin
    emit    = 1'b0;
    r_kind  = KIND_OTHER;
    r_reply = REPLY_NONE;
    r_id    = 8'h00;
    r_type  = 8'h00;
    r_len   = 8'h00;
    r_pv    = 1'b0;
    r_pb    = 8'h00;
    r_last  = 1'b1;
    unique case (state)
      S_CLASS: begin
        priority if (overflowed) begin
          emit = out_free;
        end else if (is_ack) begin
          emit   = out_free;
          r_kind = KIND_ACK;
        end else if (is_nack) begin
          emit   = out_free;
          r_kind = KIND_NACK;
        end else if (!is_msg) begin
          emit = out_free;
        end else if (len_bad) begin
          emit    = out_free;
          r_kind  = KIND_BAD;
          r_reply = REPLY_NACK;
          r_id    = b0;
          r_type  = b1;
          r_len   = b2;
        end else begin
          emit = 1'b0;
        end
      end
      S_CMP: begin
        emit   = out_free;
        r_id   = b0;
        r_type = b1;
        r_len  = b2;
        if (crc_good) begin
          r_kind  = KIND_GOOD;
          r_reply = REPLY_ACK;
          r_last  = (b2 == 8'h00);
        end else begin
          r_kind  = KIND_BAD;
          r_reply = REPLY_NACK;
        end
      end
      S_PEMIT: begin
        emit    = out_free;
        r_kind  = KIND_GOOD;
        r_reply = REPLY_ACK;
        r_id    = b0;
        r_type  = b1;
        r_len   = b2;
        r_pv    = 1'b1;
        r_pb    = pos_ok ? ram_rdata : 8'h00;
        r_last  = (8'(pay_idx + 8'd1) == b2);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    emit_last = emit && r_last;
  end

  always_comb begin
    crc_cmd.start      = byte_acc || (state == S_EXT_GO);
    crc_cmd.data       = (state == S_EXT_GO) ? 8'h00 : s_tdata;
    crc_cmd.load       = emit_last ||
                         (cfg_valid && (cfg_index == CFG_CRC_INIT) && (count == '0));
    crc_cmd.load_value = emit_last ? crc_init : cfg_data;
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = pay_pos[ADDR_W-1:0];
    unique case (state)
      S_RDHI: begin
        ram_re    = 1'b1;
        ram_raddr = end_pos[ADDR_W-1:0];
      end
      S_RDLO: begin
        ram_re    = 1'b1;
        ram_raddr = end_pos[ADDR_W-1:0] + ADDR_W'(1);
      end
      S_PRD: begin
        ram_re = 1'b1;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  ufrc_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (byte_acc),
    .waddr(count[ADDR_W-1:0]),
    .wdata(s_tdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ufrc_crc_serial u_crc (
    .clk (clk),
    .rst (rst),
    .cmd (crc_cmd),
    .busy(crc_busy),
    .crc (crc_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      idle_cnt     <= '0;
      overflowed   <= 1'b0;
      crc_end      <= '0;
      cap_pend     <= 1'b0;
      idle_timeout <= IDLE_TIMEOUT_RESET;
      crc_init     <= CRC_INIT_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_IDLE_TIMEOUT) begin
          idle_timeout <= cfg_data;
        end else if (cfg_index == CFG_CRC_INIT) begin
          crc_init <= cfg_data;
        end
      end

      if (emit) begin
        out_valid <= 1'b1;
        out_kind  <= r_kind;
        out_reply <= r_reply;
        out_id    <= r_id;
        out_type  <= r_type;
        out_len   <= r_len;
        out_pv    <= r_pv;
        out_pb    <= r_pb;
        out_last  <= r_last;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc && (s_tuser == CMD_BYTE)) begin
            idle_cnt <= '0;
            if (byte_acc) begin
              count    <= count + CNT_W'(1);
              cap_pend <= cap_now;
              state    <= S_CRC;
              if (count == CNT_W'(0)) b0 <= s_tdata;
              if (count == CNT_W'(1)) b1 <= s_tdata;
              if (count == CNT_W'(2)) b2 <= s_tdata;
              if (count == CNT_W'(3)) b3 <= s_tdata;
            end else begin
              overflowed <= 1'b1;
            end
          end else if (tick_acc && (count != '0)) begin
            idle_cnt <= idle_next;
            if (idle_next >= idle_timeout) begin
              state <= S_CLASS;
            end
          end
        end
        S_CRC: begin
          if (!crc_busy) begin
            if (cap_pend) begin
              crc_end <= crc_val;
            end
            state <= S_IDLE;
          end
        end
        S_CLASS: begin
          if (!(overflowed || is_ack || is_nack || !is_msg || len_bad)) begin
            if (cnt_w >= end_pos) begin
              crc_chk <= crc_end;
              state   <= S_RDHI;
            end else begin
              // short frame: run zeros through the CRC up to the CRC field
              ext_left <= end_pos - cnt_w;
              state    <= S_EXT_GO;
            end
          end
        end
        S_EXT_GO: begin
          ext_left <= ext_left - POS_W'(1);
          state    <= S_EXT_WAIT;
        end
        S_EXT_WAIT: begin
          if (!crc_busy) begin
            if (ext_left == '0) begin
              crc_chk <= crc_val;
              state   <= S_RDHI;
            end else begin
              state <= S_EXT_GO;
            end
          end
        end
        S_RDHI: begin
          state <= S_RDLO;
        end
        S_RDLO: begin
          rx_hi <= (end_pos < cnt_w) ? ram_rdata : 8'h00;
          state <= S_CMP;
        end
        S_CMP: begin
          if (emit && !r_last) begin
            pay_idx <= 8'h00;
            state   <= S_PRD;
          end
        end
        S_PRD: begin
          state <= S_PEMIT;
        end
        S_PEMIT: begin
          if (emit && !r_last) begin
            pay_idx <= pay_idx + 8'd1;
            state   <= S_PRD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // final result of a frame goes out: start a fresh frame
      if (emit_last) begin
        state      <= S_IDLE;
        count      <= '0;
        idle_cnt   <= '0;
        overflowed <= 1'b0;
        crc_end    <= '0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tuser  = {out_pv, out_kind};
  assign m_tdata  = {6'b000000, out_pb, out_len, out_type, out_id, out_reply};

endmodule

>>> test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ufrc_pkg::*;

  localparam int STALL_LIMIT    = 4000;
  localparam int CFG_HOLDOFF    = 20;
  localparam int END_HOLDOFF    = 40;
  localparam int PHASE_ITEMS    = 56;
  localparam int REPORT_CAP     = 200;

  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_TICK,
    ROW_CFG
  } row_op_t;

  typedef struct packed {
    row_op_t     op;
    logic [7:0]  arg;     // byte value, or register index on a cfg row
    logic [15:0] val;
    logic        typed;   // expected result typed into the row
    frame_kind_t kind;
    reply_t      reply;
    logic [7:0]  id;
    logic [7:0]  typ;
    logic [7:0]  len;
  } dir_row_t;

  typedef struct packed {
    frame_kind_t kind;
    reply_t      reply;
    logic [7:0]  id;
    logic [7:0]  typ;
    logic [7:0]  len;
    logic        pv;
    logic [7:0]  pb;
    logic        last;
  } frame_result_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata   = 8'h00;  // [7:0] rx_byte
  logic                 s_tuser   = 1'b0;   // [0] cmd
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [39:0]          m_tdata;  // [1:0] reply, [9:2] id, [17:10] type, [25:18] length,
                                  // [33:26] payload_byte
  logic [3:0]           m_tuser;  // [2:0] frame_kind, [3] payload_valid
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data  = 16'h0000;

  // predictor state
  logic [7:0]      rx_store [FRAME_DEPTH];
  int              held_bytes;
  logic [15:0]     idle_ticks;
  logic [15:0]     crc_acc;
  logic [15:0]     crc_payload_end;
  logic            store_overflow;
  logic [15:0]     timeout_ticks;
  logic [15:0]     crc_preset;

  frame_result_t   expected_results[$];
  dir_row_t        dir_rows[$];
  logic [7:0]      frame_bytes[$];

  bit              no_idle;
  int              mismatches;
  int              stall_cycles;
  int              items_sent;
  int              live_items;
  int              results_seen;
  int              frames_seen;
  int              good_seen;

  always #10 clk = ~clk;

  uart_frame_receive_classifier_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------- predictor

  function automatic logic [15:0] crc16_arc(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

  // bytes never received read as zero
  function automatic logic [7:0] held(input int pos);
    return (pos < held_bytes) ? rx_store[pos] : 8'h00;
  endfunction

  function automatic void add_result(input frame_kind_t kind, input reply_t reply,
                                     input logic [7:0] id, input logic [7:0] typ,
                                     input logic [7:0] len, input logic pv,
                                     input logic [7:0] pb, input logic last);
    frame_result_t r;
    r.kind  = kind;
    r.reply = reply;
    r.id    = id;
    r.typ   = typ;
    r.len   = len;
    r.pv    = pv;
    r.pb    = pb;
    r.last  = last;
    expected_results.push_back(r);
  endfunction

  function automatic void clear_frame();
    held_bytes      = 0;
    idle_ticks      = 16'h0000;
    store_overflow  = 1'b0;
    crc_acc         = crc_preset;
    crc_payload_end = 16'h0000;
  endfunction

  function automatic void classify_frame();
    int          len;
    logic [15:0] crc;
    logic [15:0] rx_crc;
    if (store_overflow) begin
      add_result(KIND_OTHER, REPLY_NONE, 0, 0, 0, 0, 0, 1);
    end else if (held_bytes == 3 && held(0) == CH_A && held(1) == CH_C && held(2) == CH_K) begin
      add_result(KIND_ACK, REPLY_NONE, 0, 0, 0, 0, 0, 1);
    end else if (held_bytes == 4 && held(0) == CH_N && held(1) == CH_A &&
                 held(2) == CH_C && held(3) == CH_K) begin
      add_result(KIND_NACK, REPLY_NONE, 0, 0, 0, 0, 0, 1);
    end else if (!(held_bytes > 5 && held(1) == CH_W)) begin
      add_result(KIND_OTHER, REPLY_NONE, 0, 0, 0, 0, 0, 1);
    end else begin
      len = held(2);
      if (len + 5 > FRAME_DEPTH || len > MAX_RESULTS - 1) begin
        add_result(KIND_BAD, REPLY_NACK, held(0), held(1), 8'(len), 0, 0, 1);
      end else begin
        // payload end seen on arrival, else run the missing zeros through
        if (held_bytes >= len + 3) begin
          crc = crc_payload_end;
        end else begin
          crc = crc_acc;
          for (int i = held_bytes; i < len + 3; i++) crc = crc16_arc(crc, 8'h00);
        end
        rx_crc = {held(len + 3), held(len + 4)};
        if (crc != rx_crc) begin
          add_result(KIND_BAD, REPLY_NACK, held(0), held(1), 8'(len), 0, 0, 1);
        end else begin
          add_result(KIND_GOOD, REPLY_ACK, held(0), held(1), 8'(len), 0, 0, len == 0);
          for (int i = 0; i < len; i++) begin
            add_result(KIND_GOOD, REPLY_ACK, held(0), held(1), 8'(len), 1, held(3 + i),
                       i + 1 == len);
          end
        end
      end
    end
  endfunction

  function automatic void deframe_step(input logic cmd, input logic [7:0] data);
    if (cmd == CMD_BYTE) begin
      idle_ticks = 16'h0000;
      if (held_bytes < FRAME_DEPTH) begin
        rx_store[held_bytes] = data;
        held_bytes++;
        crc_acc = crc16_arc(crc_acc, data);
        if (held_bytes >= 3 && held_bytes == rx_store[2] + 3) crc_payload_end = crc_acc;
      end else begin
        store_overflow = 1'b1;
      end
    end else if (held_bytes != 0) begin
      if (idle_ticks != 16'hFFFF) idle_ticks++;
      if (idle_ticks >= timeout_ticks) begin
        classify_frame();
        clear_frame();
      end
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_item(input logic cmd, input logic [7:0] data);
    if (!no_idle && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (cmd == CMD_BYTE || held_bytes != 0) live_items++;
    items_sent++;
    deframe_step(cmd, data);
  endtask

  // always lets an edge pass after lowering valid, so valid is never lowered and raised in one step
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    drain_results();
    repeat (CFG_HOLDOFF) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_IDLE_TIMEOUT) begin
      timeout_ticks = val;
    end else if (idx == CFG_CRC_INIT) begin
      crc_preset = val;
      if (held_bytes == 0) crc_acc = val;
    end
  endtask

  // ---------------------------------------------------------------- frame builders

  function automatic int msg_len();
    int r;
    r = $urandom_range(9);
    if (r < 7) return $urandom_range(6);
    if (r < 9) return $urandom_range(7, 20);
    return $urandom_range(40, 59);
  endfunction

  function automatic void make_message(input int len);
    logic [15:0] crc;
    frame_bytes.delete();
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(CH_W);
    frame_bytes.push_back(8'(len));
    repeat (len) frame_bytes.push_back(8'($urandom));
    crc = crc_preset;
    foreach (frame_bytes[i]) crc = crc16_arc(crc, frame_bytes[i]);
    frame_bytes.push_back(crc[15:8]);
    frame_bytes.push_back(crc[7:0]);
  endfunction

  function automatic void load_handshake_word(input bit nack);
    frame_bytes.delete();
    if (nack) frame_bytes.push_back(CH_N);
    frame_bytes.push_back(CH_A);
    frame_bytes.push_back(CH_C);
    frame_bytes.push_back(CH_K);
  endfunction

  task automatic send_frame();
    foreach (frame_bytes[i]) begin
      send_item(CMD_BYTE, frame_bytes[i]);
      // idle gaps shorter than the timeout only restart the count
      if (timeout_ticks > 1 && timeout_ticks < 8 && $urandom_range(4) == 0)
        repeat ($urandom_range(1, timeout_ticks - 1)) send_item(CMD_TICK, 8'($urandom));
    end
    while (held_bytes != 0) send_item(CMD_TICK, 8'($urandom));
  endtask

  task automatic random_frame();
    int pick;
    int len;
    int cut;
    int pos;
    pick = $urandom_range(99);
    len  = msg_len();
    frame_bytes.delete();
    if (pick < 50) begin
      make_message(len);
      if (pick >= 36) begin
        pos = $urandom_range(3, frame_bytes.size() - 1);
        frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(7));
      end
      // a bare empty message is only 5 bytes, too short to be one
      if (frame_bytes.size() < 6 || $urandom_range(7) == 0)
        frame_bytes.push_back(8'($urandom));
    end else if (pick < 60) begin
      make_message(len + 2);
      cut = $urandom_range(6, frame_bytes.size() - 1);
      while (frame_bytes.size() > cut) frame_bytes.delete(frame_bytes.size() - 1);
    end else if (pick < 68) begin
      load_handshake_word(1'b0);
    end else if (pick < 76) begin
      load_handshake_word(1'b1);
    end else if (pick < 81) begin
      load_handshake_word($urandom_range(1));
      case ($urandom_range(2))
        0: frame_bytes.delete(frame_bytes.size() - 1);
        1: frame_bytes.push_back(8'($urandom));
        default: begin
          pos = $urandom_range(frame_bytes.size() - 1);
          frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(7));
        end
      endcase
    end else if (pick < 85) begin
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(CH_W);
      frame_bytes.push_back(8'($urandom_range(60, 255)));
      repeat ($urandom_range(3, 8)) frame_bytes.push_back(8'($urandom));
    end else if (pick < 88) begin
      repeat (FRAME_DEPTH + $urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
      if ($urandom_range(1)) frame_bytes[1] = CH_W;
    end else begin
      repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom));
      if (frame_bytes.size() > 1 && $urandom_range(1)) frame_bytes[1] = CH_W;
    end
    send_frame();
  endtask

  function automatic void add_row(input row_op_t op, input logic [7:0] arg,
                                  input logic [15:0] val = 16'h0000, input logic typed = 1'b0,
                                  input frame_kind_t kind = KIND_OTHER,
                                  input reply_t reply = REPLY_NONE,
                                  input logic [7:0] id = 8'h00, input logic [7:0] typ = 8'h00,
                                  input logic [7:0] len = 8'h00);
    dir_row_t r;
    r.op    = op;
    r.arg   = arg;
    r.val   = val;
    r.typed = typed;
    r.kind  = kind;
    r.reply = reply;
    r.id    = id;
    r.typ   = typ;
    r.len   = len;
    dir_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $display("%0t: %s expected 0x%0h, got 0x%0h", $realtime, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    frame_result_t got;
    frame_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind  = frame_kind_t'(m_tuser[2:0]);
      got.pv    = m_tuser[3];
      got.reply = reply_t'(m_tdata[1:0]);
      got.id    = m_tdata[9:2];
      got.typ   = m_tdata[17:10];
      got.len   = m_tdata[25:18];
      got.pb    = m_tdata[33:26];
      got.last  = m_tlast;
      results_seen++;
      if (!got.pv) frames_seen++;
      if (!got.pv && got.kind == KIND_GOOD) good_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: result with nothing expected, kind %0d, got 0x%0h", $realtime,
                   got.kind, got);
      end else begin
        want = expected_results.pop_front();
        check_field("frame_kind", want.kind, got.kind);
        check_field("reply", want.reply, got.reply);
        check_field("msg_id", want.id, got.id);
        check_field("msg_type", want.typ, got.typ);
        check_field("msg_length", want.len, got.len);
        check_field("payload_valid", want.pv, got.pv);
        check_field("payload_byte", want.pb, got.pb);
        check_field("last", want.last, got.last);
      end
    end
  end

  always @(posedge clk) m_tready <= no_idle || ($urandom_range(99) >= 10);

  // counts cycles in which no channel moves anything
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending", stall_cycles,
               expected_results.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    int          before_row;
    int          phase_start;
    logic [7:0]  id;
    logic [7:0]  p0;
    logic [15:0] pre;
    logic [15:0] c;
    int          hit;
    bit          found;

    timeout_ticks = IDLE_TIMEOUT_RESET;
    crc_preset    = CRC_INIT_RESET;
    clear_frame();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: zero CRC preset, and the long timeout does not end the frame early
    make_message(2);
    frame_bytes.push_back(8'($urandom));
    foreach (frame_bytes[i]) send_item(CMD_BYTE, frame_bytes[i]);
    repeat (20) send_item(CMD_TICK, 8'($urandom));
    write_reg(CFG_IDLE_TIMEOUT, 16'd1);
    send_item(CMD_TICK, 8'($urandom));

    add_row(ROW_CFG, CFG_IDLE_TIMEOUT, 16'd0);
    add_row(ROW_BYTE, CH_A);
    add_row(ROW_BYTE, CH_C);
    add_row(ROW_BYTE, CH_K);
    add_row(ROW_TICK, 8'hFF, 0, 1'b1, KIND_ACK);
    add_row(ROW_CFG, CFG_IDLE_TIMEOUT, 16'd1);
    add_row(ROW_BYTE, CH_N);
    add_row(ROW_BYTE, CH_A);
    add_row(ROW_BYTE, CH_C);
    add_row(ROW_BYTE, CH_K);
    add_row(ROW_TICK, 8'h00, 0, 1'b1, KIND_NACK);
    add_row(ROW_TICK, 8'h5A);  // nothing held: ignored
    add_row(ROW_BYTE, 8'hFF);
    add_row(ROW_TICK, 8'hA5, 0, 1'b1, KIND_OTHER);
    // five bytes with 'W' second: still too short for a message
    add_row(ROW_BYTE, 8'h00);
    add_row(ROW_BYTE, CH_W);
    add_row(ROW_BYTE, 8'h00);
    add_row(ROW_BYTE, 8'h00);
    add_row(ROW_BYTE, 8'h00);
    add_row(ROW_TICK, 8'h00, 0, 1'b1, KIND_OTHER);
    // length field far past the store
    add_row(ROW_BYTE, 8'h12);
    add_row(ROW_BYTE, CH_W);
    add_row(ROW_BYTE, 8'hFF);
    add_row(ROW_BYTE, 8'hAA);
    add_row(ROW_BYTE, 8'h55);
    add_row(ROW_BYTE, 8'h01);
    add_row(ROW_TICK, 8'h00, 0, 1'b1, KIND_BAD, REPLY_NACK, 8'h12, CH_W, 8'hFF);
    add_row(ROW_CFG, 8'hA5, 16'hFFFF);  // unused index, no effect
    add_row(ROW_CFG, CFG_CRC_INIT, 16'hFFFF);

    foreach (dir_rows[r]) begin
      case (dir_rows[r].op)
        ROW_CFG:  write_reg(dir_rows[r].arg, dir_rows[r].val);
        ROW_BYTE: send_item(CMD_BYTE, dir_rows[r].arg);
        default: begin
          before_row = expected_results.size();
          send_item(CMD_TICK, dir_rows[r].arg);
          if (dir_rows[r].typed) begin
            while (expected_results.size() > before_row)
              expected_results.delete(expected_results.size() - 1);
            add_result(dir_rows[r].kind, dir_rows[r].reply, dir_rows[r].id, dir_rows[r].typ,
                       dir_rows[r].len, 1'b0, 8'h00, 1'b1);
          end
        end
      endcase
    end

    // short message, payload tail and CRC missing: pick the payload so that
    // the zero-filled CRC comes out as the zero read for the CRC field
    id  = 8'($urandom);
    p0  = 8'($urandom);
    pre = crc16_arc(crc16_arc(crc16_arc(crc16_arc(crc_preset, id), CH_W), 8'd4), p0);
    found = 1'b0;
    hit   = 0;
    for (int v = 0; v < 65536 && !found; v++) begin
      c = crc16_arc(crc16_arc(crc16_arc(pre, 8'(v >> 8)), 8'(v)), 8'h00);
      if (c == 16'h0000) begin
        found = 1'b1;
        hit   = v;
      end
    end
    frame_bytes.delete();
    frame_bytes.push_back(id);
    frame_bytes.push_back(CH_W);
    frame_bytes.push_back(8'd4);
    frame_bytes.push_back(p0);
    frame_bytes.push_back(8'(hit >> 8));
    frame_bytes.push_back(8'(hit));
    send_frame();

    // longest timeout, preset changes with and without bytes held
    write_reg(CFG_IDLE_TIMEOUT, 16'hFFFF);
    write_reg(CFG_CRC_INIT, 16'h1D0F);
    make_message(3);
    foreach (frame_bytes[i]) send_item(CMD_BYTE, frame_bytes[i]);
    repeat (40) send_item(CMD_TICK, 8'($urandom));
    write_reg(CFG_CRC_INIT, 16'h0000);
    write_reg(CFG_IDLE_TIMEOUT, 16'd1);
    send_item(CMD_TICK, 8'($urandom));

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_reg(CFG_IDLE_TIMEOUT, 16'd1);
        1: begin
          write_reg(CFG_IDLE_TIMEOUT, 16'd3);
          write_reg(CFG_CRC_INIT, 16'hFFFF);
        end
        2: begin
          write_reg(CFG_IDLE_TIMEOUT, 16'd0);
          write_reg(CFG_CRC_INIT, 16'($urandom));
        end
        3: begin
          write_reg(CFG_IDLE_TIMEOUT, 16'd2);
          write_reg(CFG_CRC_INIT, 16'($urandom));
        end
        default: begin
          write_reg(CFG_IDLE_TIMEOUT, 16'($urandom_range(1, 5)));
          write_reg(CFG_CRC_INIT, 16'($urandom));
        end
      endcase
      no_idle = (ph == 1);
      phase_start = live_items;
      while (live_items - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) send_item(CMD_TICK, 8'($urandom));
        random_frame();
        if ($urandom_range(19) == 0) drain_results();
      end
    end
    no_idle = 1'b0;

    drain_results();
    repeat (END_HOLDOFF) @(posedge clk);

    $display("sent %0d items, checked %0d results over %0d frames (%0d good messages)",
             items_sent, results_seen, frames_seen, good_seen);
    $display("reset defaults, timeouts 0 to 5 and 65535, several CRC presets, overflow, zero fill");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/ufrc_pkg.sv
rtl/core/ufrc_ram.sv
rtl/core/ufrc_crc_serial.sv
rtl/core/uart_frame_receive_classifier_unit.sv
test/tb_top.sv
